// File: hdl/sorted_priority_queue_macros.svh
// Assertion helpers shared by the queue RTL.
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// same-cycle implication, sampled on aclk, off while in reset
`define SPQ_CHECK(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SPQ_CHECK_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/spq_pkg.sv
package spq_pkg;

    localparam int KEY_W   = 32;
    localparam int KIND_W  = 3;
    localparam int POS_W   = 6;
    localparam int STAT_W  = 2;
    localparam int SLOT_W  = 6;
    localparam int REM_W   = 7;
    localparam int COUNT_W = 7;

    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 56;

    typedef enum logic [KIND_W-1:0] {
        K_OFFER     = 3'd0,
        K_POLL      = 3'd1,
        K_PEEK      = 3'd2,
        K_READ_AT   = 3'd3,
        K_REMOVE_EQ = 3'd4,
        K_REMOVE_AT = 3'd5
    } kind_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    // what every cell of the chain does this cycle
    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_DEL_AT = 2'd2,
        OP_DEL_EQ = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t                 op;
        logic signed [KEY_W-1:0]  key;
    } cell_cmd_t;

endpackage

// File: hdl/sorted_priority_queue.sv
// Sorted priority queue of up to CAPACITY signed 32-bit keys, kept ascending in a chain of
// cells, equal keys in arrival order. Every request gives exactly one result. Offer, poll,
// peek, read-at and remove-at first capture the request, then all cells compare and shift
// together as the result is registered. Remove-equal repeats the compare and shift for each
// matching entry, because the chain drops one matching entry per cycle. A finished result
// waits in the output register, so the next request may be taken meanwhile; a request
// finishes only when that register is free. Positions above 63 cannot be addressed.
module sorted_priority_queue #(
    parameter int CAPACITY = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // key [31:0], position [37:32], zero [39:38]
    input  logic [spq_pkg::S_DATA_W-1:0]      s_tdata,
    // kind [2:0]
    input  logic [spq_pkg::KIND_W-1:0]        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // status [1:0], value [33:2], slot [39:34], removed [46:40], count [53:47], zero [55:54]
    output logic [spq_pkg::M_DATA_W-1:0]      m_tdata
);
    import spq_pkg::*;

    `include "sorted_priority_queue_macros.svh"

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    typedef enum logic {S_IDLE, S_EXEC} state_t;

    state_t                  state_reg;
    kind_t                   kind_reg;
    logic signed [KEY_W-1:0] key_reg;
    logic [POS_W-1:0]        pos_reg;
    logic [CW-1:0]           occ_reg, occ_next;
    logic [CW-1:0]           rem_reg;
    logic                    m_tvalid_reg;
    logic [M_DATA_W-1:0]     m_tdata_reg;

    cell_cmd_t               cell_cmd;
    cell_op_t                op_d;

    logic signed [KEY_W-1:0] entry [CAPACITY];
    logic [CAPACITY-1:0]     le, lt, cell_valid, at_pos, sel, boundary;

    logic                    empty, full, out_range, any_eq, out_free;
    logic                    finish, fire, apply;
    logic                    offer_ok, eq_step;
    logic [XW-1:0]           pos_eff, occ_x;
    logic signed [KEY_W-1:0] sel_val;
    logic [IW-1:0]           slot_idx;

    status_t                 status_d;
    logic signed [KEY_W-1:0] value_d;
    logic [SLOT_W-1:0]       slot_d;
    logic [CW-1:0]           rem_d;
    logic [CW-1:0]           occ_after;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign empty    = (occ_reg == '0);
    assign full     = (occ_reg == CAP_C);
    assign occ_x    = XW'(occ_reg);
    assign pos_eff  = (kind_reg == K_POLL || kind_reg == K_PEEK) ? '0 : XW'(pos_reg);
    assign out_range = (XW'(pos_reg) >= occ_x);
    assign any_eq   = |(le & ~lt);
    assign out_free = !m_tvalid_reg || m_tready;

    assign cell_cmd.key = key_reg;
    assign cell_cmd.op  = apply ? op_d : OP_HOLD;

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic                    left_le_w;
        logic signed [KEY_W-1:0] left_w, right_w;

        assign cell_valid[k] = (XW'(k) < occ_x);
        assign at_pos[k]     = (XW'(k) >= pos_eff);
        assign sel[k]        = (XW'(k) == pos_eff);

        if (k == 0) begin : g_first
            assign left_le_w   = 1'b1;
            assign left_w      = key_reg;
            assign boundary[k] = !lt[k];
        end else begin : g_inner
            assign left_le_w   = le[k-1];
            assign left_w      = entry[k-1];
            assign boundary[k] = lt[k-1] && !lt[k];
        end

        if (k == CAPACITY - 1) begin : g_last
            assign right_w = entry[k];
        end else begin : g_mid
            assign right_w = entry[k+1];
        end

        spq_cell u_cell (
            .aclk        (aclk),
            .cmd         (cell_cmd),
            .valid       (cell_valid[k]),
            .at_pos      (at_pos[k]),
            .left_le     (left_le_w),
            .left_entry  (left_w),
            .right_entry (right_w),
            .entry       (entry[k]),
            .le          (le[k]),
            .lt          (lt[k])
        );
    end

    // one-hot selects and the boundary of the keys below the request key fold into OR trees
    always_comb begin
        sel_val  = '0;
        slot_idx = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            if (sel[k]) begin
                sel_val = sel_val | entry[k];
            end
            if (boundary[k]) begin
                slot_idx = slot_idx | IW'(k);
            end
        end
    end

    always_comb begin
        finish    = 1'b1;
        op_d      = OP_HOLD;
        status_d  = ST_OK;
        value_d   = '0;
        slot_d    = '0;
        rem_d     = '0;
        occ_after = occ_reg;
        case (kind_reg)
            K_OFFER: begin
                if (full) begin
                    status_d = ST_FULL;
                end else begin
                    op_d      = OP_INSERT;
                    occ_after = occ_reg + CW'(1);
                    slot_d    = SLOT_W'(slot_idx);
                end
            end
            K_POLL: begin
                if (empty) begin
                    status_d = ST_EMPTY;
                end else begin
                    op_d      = OP_DEL_AT;
                    value_d   = sel_val;
                    rem_d     = CW'(1);
                    occ_after = occ_reg - CW'(1);
                end
            end
            K_PEEK: begin
                if (empty) begin
                    status_d = ST_EMPTY;
                end else begin
                    value_d = sel_val;
                end
            end
            K_READ_AT: begin
                if (empty) begin
                    status_d = ST_EMPTY;
                end else if (out_range) begin
                    status_d = ST_RANGE;
                end else begin
                    value_d = sel_val;
                end
            end
            K_REMOVE_EQ: begin
                // the matches may drain the chain; empty counts only before the first one
                if (empty && rem_reg == '0) begin
                    status_d = ST_EMPTY;
                end else if (any_eq) begin
                    // one match leaves per cycle until none is left
                    finish    = 1'b0;
                    op_d      = OP_DEL_EQ;
                    occ_after = occ_reg - CW'(1);
                end else begin
                    rem_d   = rem_reg;
                    value_d = (rem_reg != '0) ? key_reg : '0;
                end
            end
            K_REMOVE_AT: begin
                if (empty) begin
                    status_d = ST_EMPTY;
                end else if (out_range) begin
                    status_d = ST_RANGE;
                end else begin
                    op_d      = OP_DEL_AT;
                    value_d   = sel_val;
                    rem_d     = CW'(1);
                    occ_after = occ_reg - CW'(1);
                end
            end
            default: begin
                finish = 1'b1;
            end
        endcase
    end

    assign fire     = (state_reg == S_EXEC) && finish && out_free;
    assign apply    = (state_reg == S_EXEC) && (fire || !finish);
    assign occ_next = apply ? occ_after : occ_reg;
    assign offer_ok = fire && kind_reg == K_OFFER && !full;
    assign eq_step  = apply && !finish;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            occ_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            occ_reg <= occ_next;
            if (fire) begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= {2'b00, COUNT_W'(occ_after), REM_W'(rem_d), slot_d, value_d,
                                 status_d};
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= S_EXEC;
                        kind_reg  <= kind_t'(s_tuser);
                        key_reg   <= s_tdata[KEY_W-1:0];
                        pos_reg   <= s_tdata[KEY_W+POS_W-1:KEY_W];
                        rem_reg   <= '0;
                    end
                end
                S_EXEC: begin
                    if (apply && !finish) begin
                        rem_reg <= rem_reg + CW'(1);
                    end
                    if (fire) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `SPQ_CHECK(a_occ_bound, 1'b1, occ_reg <= CAP_C, "occupancy above capacity")
    `SPQ_CHECK(a_insert_room, cell_cmd.op == OP_INSERT, !full, "insert into a full chain")
    `SPQ_CHECK_NEXT(a_offer_grows, offer_ok, occ_reg == $past(occ_reg) + CW'(1), "offer lost")
    `SPQ_CHECK_NEXT(a_remeq_step, eq_step, occ_reg == $past(occ_reg) - CW'(1), "no entry left")

endmodule

// File: hdl/spq_cell.sv
module spq_cell (
    input  logic                              aclk,
    input  spq_pkg::cell_cmd_t                cmd,
    input  logic                              valid,
    input  logic                              at_pos,
    input  logic                              left_le,
    input  logic signed [spq_pkg::KEY_W-1:0]  left_entry,
    input  logic signed [spq_pkg::KEY_W-1:0]  right_entry,
    output logic signed [spq_pkg::KEY_W-1:0]  entry,
    output logic                              le,
    output logic                              lt
);
    import spq_pkg::*;

    logic signed [KEY_W-1:0] entry_reg;
    logic signed [KEY_W-1:0] entry_next;

    assign entry = entry_reg;
    assign le    = valid && (entry_reg <= cmd.key);
    assign lt    = valid && (entry_reg <  cmd.key);

    always_comb begin
        entry_next = entry_reg;
        case (cmd.op)
            OP_INSERT: begin
                // keys greater than the newcomer move one place up
                if (!le) begin
                    entry_next = left_le ? cmd.key : left_entry;
                end
            end
            OP_DEL_AT: begin
                if (at_pos) begin
                    entry_next = right_entry;
                end
            end
            OP_DEL_EQ: begin
                // drops the first equal key: everything from it on moves down
                if (!lt) begin
                    entry_next = right_entry;
                end
            end
            default: begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule
